### rtl/gaps_pkg.sv
`default_nettype none
package gaps_pkg;

  localparam int MaxSide    = 64;
  localparam int CoordW     = 6;
  localparam int KeyW       = 2 * CoordW;
  localparam int SideW      = 7;
  localparam int MinSide    = 5;
  localparam int CostW      = 20;
  localparam int CostStraight = 10;
  localparam int CostDiag   = 14;
  localparam int CostInit   = 1000000;
  localparam int HeapDepth  = 4096;
  localparam int HeapAW     = 12;
  localparam int CountW     = 13;
  localparam int PopLimit   = 8000;
  localparam int PopW       = 13;
  localparam int LenW       = 13;
  localparam int IdxW       = 12;
  localparam int NodeW      = CostW + KeyW;
  localparam int HeapW      = CostW + KeyW;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_GOAL_BLOCKED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW     = 2'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              cell_blocked;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] goal_x;
    logic [CoordW-1:0] goal_y;
    logic [IdxW-1:0]   path_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LenW-1:0]   path_length;
    logic [CoordW-1:0] step_x;
    logic [CoordW-1:0] step_y;
    logic              last_step;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/gaps_ram.sv
`default_nettype none
module gaps_ram #(
  parameter int AddrW = 12,
  parameter int DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/gaps_engine.sv
`default_nettype none
module gaps_engine
  import gaps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire req_t              req_i,
  input  wire logic [CoordW-1:0] wm1_i,
  input  wire logic [CoordW-1:0] hm1_i,
  output logic                   idle_o,
  output logic                   rsp_valid_o,
  output rsp_t                   rsp_o,
  input  wire logic              rsp_take_i
);

  typedef enum logic [4:0] {
    S_WIPE, S_IDLE, S_PATH, S_GOAL, S_CLEAR, S_INIT, S_POP, S_TOP, S_LAST,
    S_SDL, S_SDR, S_SDC, S_CHECK, S_NBR, S_EXP, S_NCMP, S_SU, S_SUC,
    S_WALK, S_WRD, S_RESP
  } state_e;

  // neighbor cell of c in direction d: {out of grid, key}
  function automatic logic [KeyW:0] nbr_of(logic [KeyW-1:0] c, logic [2:0] d,
                                           logic [CoordW-1:0] wm1,
                                           logic [CoordW-1:0] hm1);
    logic [CoordW:0] nx;
    logic [CoordW:0] ny;
    logic            oob;
    nx = {1'b0, c[CoordW-1:0]};
    ny = {1'b0, c[KeyW-1:CoordW]};
    case (d)
      3'd0: nx = nx + 1'b1;
      3'd1: nx = nx - 1'b1;
      3'd2: ny = ny + 1'b1;
      3'd3: ny = ny - 1'b1;
      3'd4: begin nx = nx + 1'b1; ny = ny + 1'b1; end
      3'd5: begin nx = nx + 1'b1; ny = ny - 1'b1; end
      3'd6: begin nx = nx - 1'b1; ny = ny + 1'b1; end
      default: begin nx = nx - 1'b1; ny = ny - 1'b1; end
    endcase
    oob = nx[CoordW] | ny[CoordW] | (nx[CoordW-1:0] > wm1) | (ny[CoordW-1:0] > hm1);
    return {oob, ny[CoordW-1:0], nx[CoordW-1:0]};
  endfunction

  // ten times the Manhattan distance
  function automatic logic [10:0] dist10(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [CoordW:0]   s;
    dx = (a[CoordW-1:0] > b[CoordW-1:0]) ? a[CoordW-1:0] - b[CoordW-1:0]
                                         : b[CoordW-1:0] - a[CoordW-1:0];
    dy = (a[KeyW-1:CoordW] > b[KeyW-1:CoordW]) ? a[KeyW-1:CoordW] - b[KeyW-1:CoordW]
                                               : b[KeyW-1:CoordW] - a[KeyW-1:CoordW];
    s  = {1'b0, dx} + {1'b0, dy};
    return {1'b0, s, 3'b000} + {3'b000, s, 1'b0};
  endfunction

  state_e             state_q, state_d;
  logic [KeyW-1:0]    start_k_q, start_k_d, goal_k_q, goal_k_d;
  logic [KeyW-1:0]    cur_q, cur_d, nk_q, nk_d, wcur_q, wcur_d;
  logic [CostW-1:0]   cur_cost_q, cur_cost_d;
  logic [7:0]         wall_q, wall_d;
  logic [2:0]         dir_q, dir_d;
  logic [HeapW-1:0]   elem_q, elem_d, left_q, left_d;
  logic [HeapAW-1:0]  hi_q, hi_d;
  logic               rok_q, rok_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [PopW-1:0]    pops_q, pops_d;
  logic [KeyW-1:0]    clr_q, clr_d;
  logic [LenW-1:0]    wn_q, wn_d, flen_q, flen_d;
  rsp_t               rsp_q, rsp_d;

  logic               map_we, map_wdata, map_rdata;
  logic [KeyW-1:0]    map_waddr, map_raddr;
  logic               node_we;
  logic [KeyW-1:0]    node_waddr, node_raddr;
  logic [NodeW-1:0]   node_wdata, node_rdata;
  logic               heap_we;
  logic [HeapAW-1:0]  heap_waddr, heap_raddr;
  logic [HeapW-1:0]   heap_wdata, heap_rdata;
  logic               path_we;
  logic [IdxW-1:0]    path_waddr, path_raddr;
  logic [KeyW-1:0]    path_wdata, path_rdata;

  logic [KeyW:0]      nbr_cur, nbr_next, nbr_first;
  logic               blk, diag;
  logic [CostW-1:0]   newc;
  logic [13:0]        lidx, ridx;
  logic [HeapW-1:0]   best;
  logic [HeapAW-1:0]  best_i;
  logic               moved;
  logic [HeapAW-1:0]  pidx;

  gaps_ram #(.AddrW(KeyW), .DataW(1)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(map_rdata)
  );
  gaps_ram #(.AddrW(KeyW), .DataW(NodeW)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata)
  );
  gaps_ram #(.AddrW(HeapAW), .DataW(HeapW)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(heap_wdata),
    .raddr_i(heap_raddr), .rdata_o(heap_rdata)
  );
  gaps_ram #(.AddrW(IdxW), .DataW(KeyW)) u_path (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata)
  );

  assign nbr_cur   = nbr_of(cur_q, dir_q, wm1_i, hm1_i);
  assign nbr_next  = nbr_of(cur_q, dir_q + 3'd1, wm1_i, hm1_i);
  assign nbr_first = nbr_of(cur_q, 3'd0, wm1_i, hm1_i);
  assign diag     = dir_q[2];
  assign blk      = wall_q[dir_q] |
                    (diag & ((dir_q[1] ? wall_q[1] : wall_q[0]) |
                             (dir_q[0] ? wall_q[3] : wall_q[2])));
  assign newc     = cur_cost_q + (diag ? CostW'(CostDiag) : CostW'(CostStraight));
  assign lidx     = {1'b0, hi_q, 1'b0} + 14'd1;
  assign ridx     = lidx + 14'd1;
  assign pidx     = HeapAW'((hi_q - 1'b1) >> 1);

  always_comb begin
    best   = elem_q;
    best_i = hi_q;
    moved  = 1'b0;
    if (left_q < elem_q) begin
      best   = left_q;
      best_i = lidx[HeapAW-1:0];
      moved  = 1'b1;
    end
    if (rok_q && (heap_rdata < best)) begin
      best   = heap_rdata;
      best_i = ridx[HeapAW-1:0];
      moved  = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    start_k_d  = start_k_q;
    goal_k_d   = goal_k_q;
    cur_d      = cur_q;
    nk_d       = nk_q;
    wcur_d     = wcur_q;
    cur_cost_d = cur_cost_q;
    wall_d     = wall_q;
    dir_d      = dir_q;
    elem_d     = elem_q;
    left_d     = left_q;
    hi_d       = hi_q;
    rok_d      = rok_q;
    cnt_d      = cnt_q;
    pops_d     = pops_q;
    clr_d      = clr_q;
    wn_d       = wn_q;
    flen_d     = flen_q;
    rsp_d      = rsp_q;
    map_we     = 1'b0;
    map_waddr  = {req_i.cell_y, req_i.cell_x};
    map_wdata  = req_i.cell_blocked;
    map_raddr  = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    heap_we    = 1'b0;
    heap_waddr = '0;
    heap_wdata = elem_q;
    heap_raddr = '0;
    path_we    = 1'b0;
    path_waddr = wn_q[IdxW-1:0];
    path_wdata = wcur_q;
    path_raddr = '0;

    case (state_q)
      S_WIPE: begin
        // map starts all free after reset
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          rsp_d = '0;
          case (req_i.mode)
            MODE_WRITE: begin
              map_we  = 1'b1;
              state_d = S_RESP;
            end
            MODE_SEARCH: begin
              start_k_d = {req_i.start_y, req_i.start_x};
              goal_k_d  = {req_i.goal_y, req_i.goal_x};
              map_raddr = {req_i.goal_y, req_i.goal_x};
              flen_d    = '0;
              state_d   = S_GOAL;
            end
            MODE_READ: begin
              rsp_d.path_length = flen_q;
              if ({1'b0, req_i.path_index} < flen_q) begin
                path_raddr = IdxW'(flen_q - {1'b0, req_i.path_index} - 1'b1);
                rsp_d.last_step = (({1'b0, req_i.path_index} + 1'b1) == flen_q);
                state_d = S_PATH;
              end else begin
                rsp_d.status = ST_NOT_FOUND;
                state_d = S_RESP;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_PATH: begin
        rsp_d.step_x = path_rdata[CoordW-1:0];
        rsp_d.step_y = path_rdata[KeyW-1:CoordW];
        state_d = S_RESP;
      end
      S_GOAL: begin
        if (map_rdata) begin
          rsp_d.status = ST_GOAL_BLOCKED;
          state_d = S_RESP;
        end else begin
          clr_d   = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = {CostW'(CostInit), KeyW'(0)};
        clr_d      = clr_q + 1'b1;
        if (&clr_q) state_d = S_INIT;
      end
      S_INIT: begin
        node_we    = 1'b1;
        node_waddr = start_k_q;
        node_wdata = '0;
        heap_we    = 1'b1;
        heap_waddr = '0;
        heap_wdata = {CostW'(dist10(start_k_q, goal_k_q)), start_k_q};
        cnt_d      = CountW'(1);
        pops_d     = '0;
        state_d    = S_POP;
      end
      S_POP: begin
        if (cnt_q == '0 || pops_q == PopW'(PopLimit)) begin
          rsp_d.status = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          pops_d     = pops_q + 1'b1;
          heap_raddr = '0;
          state_d    = S_TOP;
        end
      end
      S_TOP: begin
        cur_d      = heap_rdata[KeyW-1:0];
        cnt_d      = cnt_q - 1'b1;
        heap_raddr = HeapAW'(cnt_q - 1'b1);
        state_d    = (cnt_q == CountW'(1)) ? S_CHECK : S_LAST;
      end
      S_LAST: begin
        elem_d  = heap_rdata;
        hi_d    = '0;
        state_d = S_SDL;
      end
      S_SDL: begin
        if (lidx >= {1'b0, cnt_q}) begin
          heap_we    = 1'b1;
          heap_waddr = hi_q;
          state_d    = S_CHECK;
        end else begin
          heap_raddr = lidx[HeapAW-1:0];
          state_d    = S_SDR;
        end
      end
      S_SDR: begin
        left_d     = heap_rdata;
        rok_d      = ridx < {1'b0, cnt_q};
        heap_raddr = ridx[HeapAW-1:0];
        state_d    = S_SDC;
      end
      S_SDC: begin
        heap_we    = 1'b1;
        heap_waddr = hi_q;
        if (moved) begin
          heap_wdata = best;
          hi_d       = best_i;
          state_d    = S_SDL;
        end else begin
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cur_q == goal_k_q) begin
          wcur_d  = goal_k_q;
          wn_d    = '0;
          state_d = S_WALK;
        end else begin
          node_raddr = cur_q;
          dir_d      = '0;
          map_raddr  = nbr_first[KeyW-1:0];
          state_d    = S_NBR;
        end
      end
      S_NBR: begin
        if (dir_q == 3'd0) cur_cost_d = node_rdata[NodeW-1:KeyW];
        wall_d[dir_q] = nbr_cur[KeyW] | map_rdata;
        dir_d = dir_q + 1'b1;
        if (dir_q == 3'd7) begin
          state_d = S_EXP;
        end else begin
          map_raddr = nbr_next[KeyW-1:0];
        end
      end
      S_EXP: begin
        if (blk) begin
          dir_d   = dir_q + 1'b1;
          state_d = (dir_q == 3'd7) ? S_POP : S_EXP;
        end else begin
          nk_d       = nbr_cur[KeyW-1:0];
          node_raddr = nbr_cur[KeyW-1:0];
          state_d    = S_NCMP;
        end
      end
      S_NCMP: begin
        if (newc < node_rdata[NodeW-1:KeyW]) begin
          if (cnt_q >= CountW'(HeapDepth)) begin
            rsp_d.status = ST_OVERFLOW;
            state_d = S_RESP;
          end else begin
            node_we    = 1'b1;
            node_waddr = nk_q;
            node_wdata = {newc, cur_q};
            elem_d     = {newc + CostW'(dist10(nk_q, goal_k_q)), nk_q};
            hi_d       = cnt_q[HeapAW-1:0];
            cnt_d      = cnt_q + 1'b1;
            state_d    = S_SU;
          end
        end else begin
          dir_d   = dir_q + 1'b1;
          state_d = (dir_q == 3'd7) ? S_POP : S_EXP;
        end
      end
      S_SU: begin
        if (hi_q == '0) begin
          heap_we    = 1'b1;
          heap_waddr = '0;
          dir_d      = dir_q + 1'b1;
          state_d    = (dir_q == 3'd7) ? S_POP : S_EXP;
        end else begin
          heap_raddr = pidx;
          state_d    = S_SUC;
        end
      end
      S_SUC: begin
        heap_we    = 1'b1;
        heap_waddr = hi_q;
        if (elem_q < heap_rdata) begin
          heap_wdata = heap_rdata;
          hi_d       = pidx;
          state_d    = S_SU;
        end else begin
          dir_d   = dir_q + 1'b1;
          state_d = (dir_q == 3'd7) ? S_POP : S_EXP;
        end
      end
      S_WALK: begin
        // path is stored goal first; reads index it from the far end
        path_we = 1'b1;
        wn_d    = wn_q + 1'b1;
        if (wcur_q == start_k_q) begin
          flen_d            = wn_q + 1'b1;
          rsp_d.status      = ST_OK;
          rsp_d.path_length = wn_q + 1'b1;
          state_d           = S_RESP;
        end else begin
          node_raddr = wcur_q;
          state_d    = S_WRD;
        end
      end
      S_WRD: begin
        wcur_d  = node_rdata[KeyW-1:0];
        state_d = S_WALK;
      end
      S_RESP: begin
        if (rsp_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
      flen_q  <= '0;
      cnt_q   <= '0;
      pops_q  <= '0;
      rsp_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      flen_q  <= flen_d;
      cnt_q   <= cnt_d;
      pops_q  <= pops_d;
      rsp_q   <= rsp_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_k_q  <= start_k_d;
    goal_k_q   <= goal_k_d;
    cur_q      <= cur_d;
    nk_q       <= nk_d;
    wcur_q     <= wcur_d;
    cur_cost_q <= cur_cost_d;
    wall_q     <= wall_d;
    dir_q      <= dir_d;
    elem_q     <= elem_d;
    left_q     <= left_d;
    hi_q       <= hi_d;
    rok_q      <= rok_d;
    wn_q       <= wn_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

### rtl/grid_astar_path_search.sv
`default_nettype none
// A* path search over a grid of up to 64 x 64 cells, 8-connected (straight
// step 10, diagonal 14, no corner cutting past a blocked side cell, heuristic
// ten times the Manhattan distance). One request is handled at a time and
// each gives exactly one result. After reset the map memory is cleared to
// all free, during which requests are stalled. Besides cell writes (mode 0)
// and path reads (mode 2), a search (mode 1) first sweeps the 4096-entry
// node memory to reset the best costs, then runs up to 8000 pops; the
// heap's sift-down and sift-up go through the single read port of the heap
// memory. A found path is then walked back from the goal. Cell keys are
// kept as {y, x}, which orders exactly like y*width+x, so no division is
// needed. A result waits in an output register, so the next request is
// taken while it is still stalled. grid_width and grid_height must be
// written only while idle; the block itself does not enforce this.
module grid_astar_path_search
  import gaps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [SideW-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [CoordW-1:0] cell_x_i,
  input  wire logic [CoordW-1:0] cell_y_i,
  input  wire logic              cell_blocked_i,
  input  wire logic [CoordW-1:0] start_x_i,
  input  wire logic [CoordW-1:0] start_y_i,
  input  wire logic [CoordW-1:0] goal_x_i,
  input  wire logic [CoordW-1:0] goal_y_i,
  input  wire logic [IdxW-1:0]   path_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [LenW-1:0]        path_length_o,
  output logic [CoordW-1:0]      step_x_o,
  output logic [CoordW-1:0]      step_y_o,
  output logic                   last_step_o
);

  // side register clamped to MinSide..MaxSide, returned minus one
  function automatic logic [CoordW-1:0] side_m1(logic [SideW-1:0] v);
    logic [SideW-1:0] s;
    s = v;
    if (v < SideW'(MinSide)) s = SideW'(MinSide);
    if (v > SideW'(MaxSide)) s = SideW'(MaxSide);
    return CoordW'(s - 1'b1);
  endfunction

  function automatic logic [CoordW-1:0] clamp(logic [CoordW-1:0] v,
                                              logic [CoordW-1:0] m);
    return (v > m) ? m : v;
  endfunction

  logic [SideW-1:0]  gw_q, gh_q;
  logic [CoordW-1:0] wm1, hm1;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;
  req_t              req;
  logic              eng_idle, rsp_valid, rsp_take, accept;
  rsp_t              rsp;

  assign wm1 = side_m1(gw_q);
  assign hm1 = side_m1(gh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= SideW'(40);
      gh_q <= SideW'(40);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  gw_q <= cfg_data_i;
        CFG_HEIGHT: gh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    req.mode         = mode_i;
    req.cell_x       = cell_x_i;
    req.cell_y       = cell_y_i;
    req.cell_blocked = cell_blocked_i;
    req.start_x      = clamp(start_x_i, wm1);
    req.start_y      = clamp(start_y_i, hm1);
    req.goal_x       = clamp(goal_x_i, wm1);
    req.goal_y       = clamp(goal_y_i, hm1);
    req.path_index   = path_index_i;
  end

  assign in_stall_o = !eng_idle;
  assign accept     = in_valid_i && eng_idle;

  gaps_engine u_engine (
    .clk_i,
    .rst_ni,
    .start_i     (accept),
    .req_i       (req),
    .wm1_i       (wm1),
    .hm1_i       (hm1),
    .idle_o      (eng_idle),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_take_i  (rsp_take)
  );

  // output register: free when empty or being taken this cycle
  assign rsp_take = rsp_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (rsp_take) begin
      out_valid_d = 1'b1;
      out_d       = rsp;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign path_length_o = out_q.path_length;
  assign step_x_o      = out_q.step_x;
  assign step_y_o      = out_q.step_y;
  assign last_step_o   = out_q.last_step;

endmodule
`default_nettype wire

### test/grid_astar_path_search_checker.sv
`default_nettype none
module grid_astar_path_search_checker
  import gaps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [SideW-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire req_t              req_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire rsp_t              rsp_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     found_len_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cells = MaxSide * MaxSide;
  localparam int StepDx [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
  localparam int StepDy [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  logic [SideW-1:0] width_q, height_q;
  bit               wall_map [Cells];
  int               g_cost [Cells];
  int               came_from [Cells];
  int               open_f [HeapDepth];
  int               open_k [HeapDepth];
  int               open_cnt;
  int               route [Cells];
  int               trail [Cells];
  int               route_len;
  rsp_t             expected_q [$];

  assign pending_o   = expected_q.size();
  assign found_len_o = route_len;

  function automatic int side_of(logic [SideW-1:0] r);
    if (r < MinSide) return MinSide;
    if (r > MaxSide) return MaxSide;
    return int'(r);
  endfunction

  function automatic bit is_wall(int x, int y, int w, int h);
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b1;
    return wall_map[y * MaxSide + x];
  endfunction

  function automatic bit ahead(int fa, int ka, int fb, int kb);
    return fa < fb || (fa == fb && ka < kb);
  endfunction

  function automatic void open_swap(int a, int b);
    int t;
    t = open_f[a]; open_f[a] = open_f[b]; open_f[b] = t;
    t = open_k[a]; open_k[a] = open_k[b]; open_k[b] = t;
  endfunction

  function automatic void open_push(int f, int k);
    int i, p;
    i = open_cnt;
    open_cnt++;
    open_f[i] = f;
    open_k[i] = k;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ahead(open_f[i], open_k[i], open_f[p], open_k[p])) break;
      open_swap(i, p);
      i = p;
    end
  endfunction

  function automatic int open_pop();
    int top, i, l, r, m;
    top = open_k[0];
    i = 0;
    open_cnt--;
    open_f[0] = open_f[open_cnt];
    open_k[0] = open_k[open_cnt];
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < open_cnt && ahead(open_f[l], open_k[l], open_f[m], open_k[m])) m = l;
      if (r < open_cnt && ahead(open_f[r], open_k[r], open_f[m], open_k[m])) m = r;
      if (m == i) break;
      open_swap(i, m);
      i = m;
    end
    return top;
  endfunction

  function automatic int dist10(int x, int y, int gx, int gy);
    return ((x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y)) * 10;
  endfunction

  function automatic logic [1:0] find_route(int sxi, int syi, int gxi, int gyi);
    int w, h, sx, sy, gx, gy, total, sk, gk, pops, cur, cx, cy, nx, ny, nk, c, n;
    bit found, diag;
    w  = side_of(width_q);
    h  = side_of(height_q);
    sx = sxi > w - 1 ? w - 1 : sxi;
    sy = syi > h - 1 ? h - 1 : syi;
    gx = gxi > w - 1 ? w - 1 : gxi;
    gy = gyi > h - 1 ? h - 1 : gyi;
    total = w * h;
    sk = sy * w + sx;
    gk = gy * w + gx;
    pops = 0;
    found = 1'b0;
    route_len = 0;
    if (is_wall(gx, gy, w, h)) return ST_GOAL_BLOCKED;
    for (int i = 0; i < total; i++) begin
      g_cost[i] = CostInit;
      came_from[i] = 0;
    end
    open_cnt = 0;
    g_cost[sk] = 0;
    open_push(dist10(sx, sy, gx, gy), sk);
    while (open_cnt > 0 && pops < PopLimit) begin
      pops++;
      cur = open_pop();
      if (cur == gk) begin
        found = 1'b1;
        break;
      end
      cx = cur % w;
      cy = cur / w;
      for (int d = 0; d < 8; d++) begin
        nx = cx + StepDx[d];
        ny = cy + StepDy[d];
        diag = StepDx[d] != 0 && StepDy[d] != 0;
        if (is_wall(nx, ny, w, h)) continue;
        // no corner cutting past a blocked side cell
        if (diag && (is_wall(nx, cy, w, h) || is_wall(cx, ny, w, h))) continue;
        nk = ny * w + nx;
        c = g_cost[cur] + (diag ? CostDiag : CostStraight);
        if (c < g_cost[nk]) begin
          if (open_cnt >= HeapDepth) return ST_OVERFLOW;
          came_from[nk] = cur;
          g_cost[nk] = c;
          open_push(c + dist10(nx, ny, gx, gy), nk);
        end
      end
    end
    if (!found) return ST_NOT_FOUND;
    n = 0;
    cur = gk;
    while (n < total) begin
      trail[n] = cur;
      n++;
      if (cur == sk) break;
      cur = came_from[cur % total];
    end
    for (int i = 0; i < n; i++) begin
      c = trail[n - 1 - i];
      route[i] = (c / w) * MaxSide + (c % w);
    end
    route_len = n;
    return ST_OK;
  endfunction

  function automatic rsp_t predict(req_t r);
    rsp_t e;
    e = '0;
    case (r.mode)
      MODE_WRITE: begin
        wall_map[int'(r.cell_y) * MaxSide + int'(r.cell_x)] = r.cell_blocked;
      end
      MODE_SEARCH: begin
        e.status = find_route(r.start_x, r.start_y, r.goal_x, r.goal_y);
        e.path_length = LenW'(route_len);
      end
      MODE_READ: begin
        e.path_length = LenW'(route_len);
        if (int'(r.path_index) < route_len) begin
          e.step_x = CoordW'(route[r.path_index] % MaxSide);
          e.step_y = CoordW'(route[r.path_index] / MaxSide);
          e.last_step = (int'(r.path_index) + 1 == route_len);
        end else begin
          e.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return e;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      width_q   <= 7'd40;
      height_q  <= 7'd40;
      route_len = 0;
      errors_o  = 0;
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) expected_q = {expected_q, predict(req_i)};
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (rsp_i.status != e.status) report("status", rsp_i.status, e.status);
          if (rsp_i.path_length != e.path_length)
            report("path_length", rsp_i.path_length, e.path_length);
          if (rsp_i.step_x != e.step_x) report("step_x", rsp_i.step_x, e.step_x);
          if (rsp_i.step_y != e.step_y) report("step_y", rsp_i.step_y, e.step_y);
          if (rsp_i.last_step != e.last_step)
            report("last_step", rsp_i.last_step, e.last_step);
        end
      end
    end
  end
endmodule
`default_nettype wire

### test/grid_astar_path_search_tb.sv
`default_nettype none
module grid_astar_path_search_tb;
  import gaps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // idle patterns, one per phase
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  localparam int ReqW = $bits(req_t);

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_index_i = CFG_WIDTH;
  logic [SideW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  req_t             req_q = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  rsp_t             rsp;
  int               errors, pending, found_len;
  int               send_idle = 0;   // percent of cycles the sender holds off
  int               recv_idle = 0;   // percent of cycles the receiver stalls
  int               cur_w = 40, cur_h = 40;

  always #2 clk_i = ~clk_i;

  grid_astar_path_search u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .mode_i(req_q.mode), .cell_x_i(req_q.cell_x), .cell_y_i(req_q.cell_y),
    .cell_blocked_i(req_q.cell_blocked), .start_x_i(req_q.start_x),
    .start_y_i(req_q.start_y), .goal_x_i(req_q.goal_x), .goal_y_i(req_q.goal_y),
    .path_index_i(req_q.path_index),
    .out_valid_o, .out_stall_i,
    .status_o(rsp.status), .path_length_o(rsp.path_length),
    .step_x_o(rsp.step_x), .step_y_o(rsp.step_y), .last_step_o(rsp.last_step)
  );

  grid_astar_path_search_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_i(req_q),
    .out_valid_i(out_valid_o), .out_stall_i, .rsp_i(rsp),
    .errors_o(errors), .pending_o(pending), .found_len_o(found_len)
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle);

  // one request; called and returns at a rising edge
  task automatic send_req(req_t r);
    int gap;
    bit took;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_q <= r;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic wall_req(int x, int y, bit b);
    req_t r;
    r = '0;
    r.mode = MODE_WRITE;
    r.cell_x = CoordW'(x);
    r.cell_y = CoordW'(y);
    r.cell_blocked = b;
    send_req(r);
  endtask

  task automatic search_req(int sx, int sy, int gx, int gy);
    req_t r;
    r = '0;
    r.mode = MODE_SEARCH;
    r.start_x = CoordW'(sx);
    r.start_y = CoordW'(sy);
    r.goal_x = CoordW'(gx);
    r.goal_y = CoordW'(gy);
    send_req(r);
  endtask

  task automatic read_req(int idx);
    req_t r;
    r = '0;
    r.mode = MODE_READ;
    r.path_index = IdxW'(idx);
    send_req(r);
  endtask

  // drain, let the block settle, then program both sides of the grid
  task automatic set_grid(int w, int h);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i <= SideW'(w);
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i <= SideW'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = w < MinSide ? MinSide : (w > MaxSide ? MaxSide : w);
    cur_h = h < MinSide ? MinSide : (h > MaxSide ? MaxSide : h);
  endtask

  // random request: mostly in-grid, sometimes anywhere in the 6-bit range
  task automatic random_req();
    int pick;
    req_t r;
    pick = $urandom_range(99);
    r = req_t'(ReqW'({$urandom, $urandom}));
    if (pick < 45) begin
      r.mode = MODE_WRITE;
      if ($urandom_range(9) != 0) begin
        r.cell_x = CoordW'($urandom_range(cur_w - 1));
        r.cell_y = CoordW'($urandom_range(cur_h - 1));
      end
      r.cell_blocked = ($urandom_range(99) < 35);
    end else if (pick < 75) begin
      r.mode = MODE_SEARCH;
      if ($urandom_range(4) != 0) begin
        r.start_x = CoordW'($urandom_range(cur_w - 1));
        r.start_y = CoordW'($urandom_range(cur_h - 1));
        r.goal_x = CoordW'($urandom_range(cur_w - 1));
        r.goal_y = CoordW'($urandom_range(cur_h - 1));
      end
    end else if (pick < 97) begin
      r.mode = MODE_READ;
      // mostly inside the stored path, one past it now and then
      if ($urandom_range(7) != 0) r.path_index = IdxW'($urandom_range(found_len));
    end else begin
      r.mode = MODE_NONE;
    end
    send_req(r);
  endtask

  initial begin
    int sides [6][2];
    idle_e mode_of [6];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset grid (40 x 40)
    search_req(0, 0, 39, 39);        // open diagonal run
    read_req(0);
    read_req(found_len - 1);         // goal entry
    read_req(found_len);             // just past the end
    read_req(4095);
    search_req(63, 63, 0, 63);       // both ends clamped
    wall_req(10, 10, 1'b1);
    search_req(0, 0, 10, 10);        // goal on a wall
    search_req(10, 10, 12, 12);      // start on a wall still runs
    wall_req(38, 39, 1'b1);
    wall_req(38, 38, 1'b1);
    wall_req(39, 38, 1'b1);
    search_req(0, 0, 39, 39);        // goal sealed off: not found
    read_req(0);                     // path dropped after a failure
    wall_req(38, 39, 1'b0);
    wall_req(39, 38, 1'b0);
    wall_req(63, 63, 1'b1);          // outside the grid in use
    search_req(30, 30, 39, 39);
    read_req(1);
    send_req('{mode: MODE_NONE, default: '1});

    // random phases; grid extremes, mostly small sizes
    sides = '{'{0, 3}, '{127, 127}, '{5, 16}, '{12, 9}, '{64, 5}, '{7, 40}};
    mode_of = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND, IDLE_NONE};
    for (int p = 0; p < 6; p++) begin
      set_grid(sides[p][0], sides[p][1]);
      send_idle = (mode_of[p] == IDLE_SEND) ? 78 : (mode_of[p] == IDLE_BOTH) ? 26 : 0;
      recv_idle = (mode_of[p] == IDLE_RECV) ? 78 : (mode_of[p] == IDLE_BOTH) ? 26 : 0;
      repeat (14) random_req();
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("grid_astar_path_search_tb: done, clean");
    end else begin
      $display("grid_astar_path_search_tb: done, errors");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000_000;
    $display("grid_astar_path_search_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
rtl/gaps_pkg.sv
rtl/gaps_ram.sv
rtl/gaps_engine.sv
rtl/grid_astar_path_search.sv
test/grid_astar_path_search_checker.sv
test/grid_astar_path_search_tb.sv
